/* hw/rtl/ted_pkg.sv */
package ted_pkg;

  typedef enum logic [2:0] {
    ENC_UTF8     = 3'd0,
    ENC_UTF8_BOM = 3'd1,
    ENC_UTF16LE  = 3'd2,
    ENC_UTF16BE  = 3'd3,
    ENC_ANSI     = 3'd4
  } enc_class_t;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClassW = 3;
  localparam int unsigned OutW   = 8;

  localparam logic [ByteW-1:0] BomB0 = 8'hEF;
  localparam logic [ByteW-1:0] BomB1 = 8'hBB;
  localparam logic [ByteW-1:0] BomB2 = 8'hBF;
  localparam logic [ByteW-1:0] ByteFf = 8'hFF;
  localparam logic [ByteW-1:0] ByteFe = 8'hFE;

endpackage

/* hw/rtl/text_encoding_detector_unit.sv */
// Text encoding detector. Bytes of a stream enter one per beat on the in_
// channel, with in_tlast on the final byte; that beat yields exactly one
// out_ beat carrying the encoding class (0 UTF-8, 1 UTF-8 with BOM,
// 2 UTF-16LE, 3 UTF-16BE, 4 ANSI), and all other beats yield none. BOM
// prefixes take priority over the UTF-8 structure check, and a multi-byte
// sequence cut short by the end of the stream counts as invalid. The block
// takes one byte per clock: each byte updates a few state registers, and
// the class is held in an output register, so input keeps flowing as long
// as results are drained, stalling only while that register is full and not
// being drained. The class appears in the cycle after the last byte.
module text_encoding_detector_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ted_pkg::ByteW-1:0] in_tdata,   // [7:0] byte_value
  input  logic                      in_tlast,   // last_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ted_pkg::OutW-1:0]  out_tdata   // [2:0] encoding_class, [7:3] zero
);
  import ted_pkg::*;

  logic [1:0]       seen_r, seen_nxt;
  logic [ByteW-1:0] lead0_r, lead0_nxt;
  logic [ByteW-1:0] lead1_r, lead1_nxt;
  logic             bom_r, bom_nxt;
  logic [1:0]       cont_r, cont_nxt;
  logic             inval_r, inval_nxt;
  logic             out_valid_r, out_valid_nxt;
  enc_class_t       out_class_r, out_class_nxt;

  logic             in_fire;
  logic [1:0]       seen_upd;
  logic [ByteW-1:0] lead0_upd, lead1_upd;
  logic             bom_upd;
  logic [1:0]       cont_upd;
  logic             inval_upd;
  enc_class_t       class_upd;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Stream state after folding in the current byte.
  always_comb begin
    lead0_upd = lead0_r;
    lead1_upd = lead1_r;
    bom_upd   = bom_r;
    case (seen_r)
      2'd0: begin
        lead0_upd = in_tdata;
        bom_upd   = (in_tdata == BomB0);
      end
      2'd1: begin
        lead1_upd = in_tdata;
        bom_upd   = bom_r && (in_tdata == BomB1);
      end
      2'd2: bom_upd = bom_r && (in_tdata == BomB2);
      default: bom_upd = bom_r;
    endcase
    seen_upd = (seen_r == 2'd3) ? seen_r : seen_r + 2'd1;

    cont_upd  = cont_r;
    inval_upd = inval_r;
    if (!inval_r) begin
      if (cont_r != 2'd0) begin
        if (in_tdata[7:6] != 2'b10) begin
          inval_upd = 1'b1;
        end else begin
          cont_upd = cont_r - 2'd1;
        end
      end else if (in_tdata[7]) begin
        if (in_tdata[7:5] == 3'b110) begin
          cont_upd = 2'd1;
        end else if (in_tdata[7:4] == 4'b1110) begin
          cont_upd = 2'd2;
        end else if (in_tdata[7:3] == 5'b11110) begin
          cont_upd = 2'd3;
        end else begin
          inval_upd = 1'b1;
        end
      end
    end

    if (seen_upd >= 2'd2 && lead0_upd == ByteFf && lead1_upd == ByteFe) begin
      class_upd = ENC_UTF16LE;
    end else if (seen_upd >= 2'd2 && lead0_upd == ByteFe && lead1_upd == ByteFf) begin
      class_upd = ENC_UTF16BE;
    end else if (seen_upd == 2'd3 && bom_upd) begin
      class_upd = ENC_UTF8_BOM;
    end else if (inval_upd || cont_upd != 2'd0) begin
      class_upd = ENC_ANSI;
    end else begin
      class_upd = ENC_UTF8;
    end
  end

  always_comb begin
    seen_nxt      = seen_r;
    lead0_nxt     = lead0_r;
    lead1_nxt     = lead1_r;
    bom_nxt       = bom_r;
    cont_nxt      = cont_r;
    inval_nxt     = inval_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_class_nxt = out_class_r;
    if (in_fire) begin
      if (in_tlast) begin
        // End of stream: publish the class and start the next stream clean.
        seen_nxt      = 2'd0;
        lead0_nxt     = '0;
        lead1_nxt     = '0;
        bom_nxt       = 1'b0;
        cont_nxt      = 2'd0;
        inval_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        out_class_nxt = class_upd;
      end else begin
        seen_nxt  = seen_upd;
        lead0_nxt = lead0_upd;
        lead1_nxt = lead1_upd;
        bom_nxt   = bom_upd;
        cont_nxt  = cont_upd;
        inval_nxt = inval_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 2'd0;
      lead0_r     <= '0;
      lead1_r     <= '0;
      bom_r       <= 1'b0;
      cont_r      <= 2'd0;
      inval_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      lead0_r     <= lead0_nxt;
      lead1_r     <= lead1_nxt;
      bom_r       <= bom_nxt;
      cont_r      <= cont_nxt;
      inval_r     <= inval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutW-ClassW){1'b0}}, out_class_r};

endmodule

/* hw/rtl/ted_checker.sv */
module ted_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      in_tlast,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [ted_pkg::OutW-1:0]  out_tdata
);
  import ted_pkg::*;

  // The last byte of a stream always produces a result beat next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("no result after last byte");

  // A byte that does not end the stream never produces a result on its own.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tlast && (!out_tvalid || out_tready))
      |=> !out_tvalid)
    else $error("result without a last byte");

  // The result register never blocks input while it is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Padding bits are zero and the class stays in its legal range.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OutW-1:ClassW] == '0 &&
                    out_tdata[ClassW-1:0] <= ENC_ANSI))
    else $error("bad encoding class on output");

endmodule

bind text_encoding_detector_unit ted_checker u_ted_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/sv/encoding_class_checker.sv */
module encoding_class_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [ted_pkg::ByteW-1:0] in_tdata,   // [7:0] byte_value
  input  logic                      in_tlast,   // last_byte
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [ted_pkg::OutW-1:0]  out_tdata,  // [2:0] encoding_class, [7:3] zero
  output int                        fail_count,
  output int                        classes_owed
);
  import ted_pkg::*;

  // Running picture of the stream in progress.
  logic [1:0]       bytes_seen;
  logic [ByteW-1:0] first_byte;
  logic [ByteW-1:0] second_byte;
  logic             bom_so_far;
  logic [1:0]       cont_owed;
  logic             broken;

  // Classes of finished streams whose result beat has not come out yet.
  enc_class_t       stream_classes[$];

  initial begin
    fail_count   = 0;
    classes_owed = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_stream();
    bytes_seen  = 2'd0;
    first_byte  = '0;
    second_byte = '0;
    bom_so_far  = 1'b0;
    cont_owed   = 2'd0;
    broken      = 1'b0;
  endtask

  task automatic absorb_byte(input logic [ByteW-1:0] b);
    case (bytes_seen)
      2'd0: begin
        first_byte = b;
        bom_so_far = (b == BomB0);
      end
      2'd1: begin
        second_byte = b;
        bom_so_far  = bom_so_far && (b == BomB1);
      end
      2'd2: begin
        bom_so_far = bom_so_far && (b == BomB2);
      end
      default: begin
      end
    endcase
    if (bytes_seen != 2'd3) bytes_seen = bytes_seen + 2'd1;

    // Once the structure is broken it stays broken for the rest of the stream.
    if (!broken) begin
      if (cont_owed != 2'd0) begin
        if (b[7:6] != 2'b10) broken = 1'b1;
        else cont_owed = cont_owed - 2'd1;
      end else if (b[7]) begin
        if (b[7:5] == 3'b110) cont_owed = 2'd1;
        else if (b[7:4] == 4'b1110) cont_owed = 2'd2;
        else if (b[7:3] == 5'b11110) cont_owed = 2'd3;
        else broken = 1'b1;
      end
    end
  endtask

  function automatic enc_class_t stream_class();
    if (bytes_seen >= 2'd2 && first_byte == ByteFf && second_byte == ByteFe) return ENC_UTF16LE;
    if (bytes_seen >= 2'd2 && first_byte == ByteFe && second_byte == ByteFf) return ENC_UTF16BE;
    if (bytes_seen == 2'd3 && bom_so_far) return ENC_UTF8_BOM;
    if (broken || cont_owed != 2'd0) return ENC_ANSI;
    return ENC_UTF8;
  endfunction

  always @(posedge clk) begin : watch
    enc_class_t want;
    if (!rst_n) begin
      clear_stream();
      stream_classes.delete();
    end else begin
      // The result of a stream comes no earlier than the cycle after its last byte, so the
      // output beat is checked before this edge's input beat is absorbed.
      if (out_tvalid && out_tready) begin
        if (stream_classes.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%02h with no stream ended", out_tdata));
        end else begin
          want = stream_classes.pop_front();
          if (out_tdata[ClassW-1:0] !== want)
            report_mismatch($sformatf("encoding_class %0d, expected %0d (%s)",
                                      out_tdata[ClassW-1:0], want, want.name()));
          if (out_tdata[OutW-1:ClassW] !== '0)
            report_mismatch($sformatf("padding bits of result are 0x%02h",
                                      out_tdata[OutW-1:ClassW]));
        end
      end
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata);
        if (in_tlast) begin
          stream_classes.push_back(stream_class());
          clear_stream();
        end
      end
    end
    classes_owed = stream_classes.size();
  end

endmodule

/* tb/sv/text_encoding_detector_unit_test.sv */
module text_encoding_detector_unit_test;
  import ted_pkg::*;

  localparam logic [ByteW-1:0] Lead2    = 8'hC0;
  localparam logic [ByteW-1:0] Lead3    = 8'hE0;
  localparam logic [ByteW-1:0] Lead4    = 8'hF0;
  localparam logic [ByteW-1:0] ContMark = 8'h80;
  localparam logic [ByteW-1:0] Openers [3] = '{BomB0, ByteFf, ByteFe};

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [ByteW-1:0] in_tdata   = '0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OutW-1:0]  out_tdata;

  int               fail_count;
  int               classes_owed;
  logic             bursty     = 1'b1;
  logic             hold_req   = 1'b0;
  int               bytes_sent = 0;
  logic [ByteW-1:0] stream_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_encoding_detector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  encoding_class_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .classes_owed (classes_owed)
  );

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    if (bursty && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic push_stream();
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  // Appends one well-formed character of 1 to 4 bytes.
  task automatic add_char();
    int n;
    n = $urandom_range(1, 4);
    case (n)
      1: stream_bytes.push_back(ByteW'($urandom_range(0, 127)));
      2: stream_bytes.push_back(Lead2 | ByteW'($urandom_range(0, 31)));
      3: stream_bytes.push_back(Lead3 | ByteW'($urandom_range(0, 15)));
      default: stream_bytes.push_back(Lead4 | ByteW'($urandom_range(0, 7)));
    endcase
    repeat (n - 1) stream_bytes.push_back(ContMark | ByteW'($urandom_range(0, 63)));
  endtask

  task automatic random_stream();
    int  kind;
    int  chars;
    bit  noisy;
    stream_bytes.delete();
    kind = $urandom_range(0, 9);
    case (kind)
      0: stream_bytes = '{ByteFf, ByteFe};
      1: stream_bytes = '{ByteFe, ByteFf};
      2, 3: stream_bytes = '{BomB0, BomB1, BomB2};
      4: begin
        // A prefix that starts like a marker and then goes astray.
        stream_bytes.push_back(Openers[$urandom_range(0, 2)]);
        if ($urandom_range(0, 1) == 1) stream_bytes.push_back(BomB1);
        stream_bytes.push_back(ByteW'($urandom));
      end
      default: begin
      end
    endcase
    noisy = (kind == 9) || ($urandom_range(0, 5) == 0);
    chars = $urandom_range(0, 6);
    repeat (chars) begin
      if (noisy) stream_bytes.push_back(ByteW'($urandom));
      else add_char();
    end
    if (stream_bytes.size() == 0) add_char();
    // Cut a sequence short, or spoil one byte somewhere.
    if (stream_bytes.size() > 1 && $urandom_range(0, 5) == 0) void'(stream_bytes.pop_back());
    if ($urandom_range(0, 7) == 0)
      stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] = ByteW'($urandom);
    push_stream();
  endtask

  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (bursty && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    stream_bytes = '{ByteFf, ByteFe};               push_stream();
    stream_bytes = '{ByteFe, ByteFf};               push_stream();
    stream_bytes = '{BomB0, BomB1, BomB2};          push_stream();
    stream_bytes = '{8'h41};                        push_stream();
    stream_bytes = '{ByteFf};                       push_stream();
    stream_bytes = '{8'hC3};                        push_stream();
    stream_bytes = '{8'hE2, 8'h82, 8'hAC, 8'h7F};   push_stream();
    stream_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};   push_stream();
    stream_bytes = '{BomB0, BomB1};                 push_stream();
    stream_bytes = '{8'h80, 8'h00};                 push_stream();
    stream_bytes = '{8'hF8};                        push_stream();
    stream_bytes = '{BomB0, BomB1, BomB2, ByteFf};  push_stream();

    while (bytes_sent < 600) random_stream();

    // Keep offering short streams while a stalled sink keeps the result register full.
    hold_req = 1'b1;
    repeat (12) begin
      stream_bytes.delete();
      repeat ($urandom_range(1, 2)) stream_bytes.push_back(ByteW'($urandom));
      push_stream();
    end

    while (bytes_sent < 1150) random_stream();
    bursty = 1'b0;
    while (bytes_sent < 1420) random_stream();
    in_tvalid <= 1'b0;

    while (classes_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && classes_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
